// ----- hdl/rsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types and constants for the ray segment intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

   // digit width of the staged wide multiplier in the reach test
   localparam int unsigned MUL_DIGIT_W = 16;

   // stage control handed to each pipelined unit
   typedef struct packed {
      logic adv;     // whole pipeline moves one stage
      logic valid;   // item presented to the unit's first stage
   } rsi_ctl_type;

endpackage

// ----- hdl/rsi_if.sv -----
// ----------------------------------------------------------------------------
// rsi_req_if / rsi_rsp_if
// Valid/ready channels carrying ray pairs in and intersection results out.
// ----------------------------------------------------------------------------
interface rsi_req_if #(parameter int COORD_WIDTH = 32) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] a_start_x;
   logic signed [COORD_WIDTH-1:0] a_start_y;
   logic signed [COORD_WIDTH-1:0] a_dir_x;
   logic signed [COORD_WIDTH-1:0] a_dir_y;
   logic        [COORD_WIDTH-2:0] a_reach;
   logic signed [COORD_WIDTH-1:0] b_start_x;
   logic signed [COORD_WIDTH-1:0] b_start_y;
   logic signed [COORD_WIDTH-1:0] b_dir_x;
   logic signed [COORD_WIDTH-1:0] b_dir_y;
   logic        [COORD_WIDTH-2:0] b_reach;

   modport source (output valid, a_start_x, a_start_y, a_dir_x, a_dir_y, a_reach,
                   b_start_x, b_start_y, b_dir_x, b_dir_y, b_reach, input ready);
   modport sink (input valid, a_start_x, a_start_y, a_dir_x, a_dir_y, a_reach,
                 b_start_x, b_start_y, b_dir_x, b_dir_y, b_reach, output ready);
endinterface

interface rsi_rsp_if #(parameter int COORD_WIDTH = 32) ();
   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [COORD_WIDTH-2:0] hit_time;

   modport source (output valid, hit, hit_time, input ready);
   modport sink (input valid, hit, hit_time, output ready);
endinterface

// ----- hdl/ray_segment_intersection_top.sv -----
// ----------------------------------------------------------------------------
// ray_segment_intersection_top
// Crossing test of two 2-D rays with reach limits, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake     | payload
//  req_chan  | in        | valid / ready | two rays: start, direction, reach
//  rsp_chan  | out       | valid / ready | hit, hit_time
//
//  one item enters per cycle unless a result waits untaken on rsp_chan; the
//  pipeline depth is set by the bit-per-stage quotient pipelines and the staged
//  reach multiply
//  reset is synchronous and clears only the stage valid bits
//  the whole pipeline holds while a result waits untaken on rsp_chan
// ----------------------------------------------------------------------------
module ray_segment_intersection_top #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic      clock,
   input  logic      reset,
   rsi_req_if.sink   req_chan,
   rsi_rsp_if.source rsp_chan
);
   import rsi_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int FB  = FRAC_BITS;
   localparam int RW  = CW - 1;
   localparam int DXW = CW + 1;
   localparam int PW  = 2 * CW;
   localparam int NW1 = 2 * CW + 1;
   localparam int NTW = 2 * CW + 2;
   localparam int QB  = CW - 1 + FB;
   localparam int CPW = 3 * CW - 1;
   localparam int DTW = 1 + RW + PW;
   localparam int RTW = 1 + RW;

   logic        rsp_valid_ff;
   logic        adv;
   rsi_ctl_type div_ctl;
   rsi_ctl_type rch_ctl_t;
   rsi_ctl_type rch_ctl_u;

   // whole pipeline moves unless the output register holds a waiting result
   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // stage 1: offsets, direction products and squares
   logic                  p1_v_ff;
   logic signed [DXW-1:0] dx_ff, dy_ff;
   logic signed [PW-1:0]  rxsy_ff, rysx_ff;
   logic        [PW-1:0]  rxx_ff, ryy_ff, sxx_ff, syy_ff;
   logic signed [CW-1:0]  rx_ff, ry_ff, sx_ff, sy_ff;
   logic        [RW-1:0]  p1_ra_ff, p1_rb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else if (adv) begin
         p1_v_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff    <= DXW'(req_chan.b_start_x) - DXW'(req_chan.a_start_x);
         dy_ff    <= DXW'(req_chan.b_start_y) - DXW'(req_chan.a_start_y);
         rxsy_ff  <= PW'(req_chan.a_dir_x) * PW'(req_chan.b_dir_y);
         rysx_ff  <= PW'(req_chan.a_dir_y) * PW'(req_chan.b_dir_x);
         rxx_ff   <= $unsigned(PW'(req_chan.a_dir_x) * PW'(req_chan.a_dir_x));
         ryy_ff   <= $unsigned(PW'(req_chan.a_dir_y) * PW'(req_chan.a_dir_y));
         sxx_ff   <= $unsigned(PW'(req_chan.b_dir_x) * PW'(req_chan.b_dir_x));
         syy_ff   <= $unsigned(PW'(req_chan.b_dir_y) * PW'(req_chan.b_dir_y));
         rx_ff    <= req_chan.a_dir_x;
         ry_ff    <= req_chan.a_dir_y;
         sx_ff    <= req_chan.b_dir_x;
         sy_ff    <= req_chan.b_dir_y;
         p1_ra_ff <= req_chan.a_reach;
         p1_rb_ff <= req_chan.b_reach;
      end
   end

   // stage 2: denominator, numerator products, squared lengths
   logic                  p2_v_ff;
   logic signed [NW1-1:0] den_ff, tp1_ff, tp2_ff, up1_ff, up2_ff;
   logic        [PW-1:0]  p2_la_ff, p2_lb_ff;
   logic        [RW-1:0]  p2_ra_ff, p2_rb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_v_ff <= 1'b0;
      end else if (adv) begin
         p2_v_ff <= p1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff   <= NW1'(rxsy_ff) - NW1'(rysx_ff);
         tp1_ff   <= NW1'(dx_ff) * NW1'(sy_ff);
         tp2_ff   <= NW1'(dy_ff) * NW1'(sx_ff);
         up1_ff   <= NW1'(dx_ff) * NW1'(ry_ff);
         up2_ff   <= NW1'(dy_ff) * NW1'(rx_ff);
         p2_la_ff <= rxx_ff + ryy_ff;
         p2_lb_ff <= sxx_ff + syy_ff;
         p2_ra_ff <= p1_ra_ff;
         p2_rb_ff <= p1_rb_ff;
      end
   end

   // stage 3: numerators
   logic                  p3_v_ff;
   logic signed [NW1-1:0] p3_den_ff;
   logic signed [NTW-1:0] nt_ff, nu_ff;
   logic        [PW-1:0]  p3_la_ff, p3_lb_ff;
   logic        [RW-1:0]  p3_ra_ff, p3_rb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_v_ff <= 1'b0;
      end else if (adv) begin
         p3_v_ff <= p2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_den_ff <= den_ff;
         nt_ff     <= NTW'(tp1_ff) - NTW'(tp2_ff);
         nu_ff     <= NTW'(up1_ff) - NTW'(up2_ff);
         p3_la_ff  <= p2_la_ff;
         p3_lb_ff  <= p2_lb_ff;
         p3_ra_ff  <= p2_ra_ff;
         p3_rb_ff  <= p2_rb_ff;
      end
   end

   // stage 4: sign checks and magnitudes
   logic          p4_v_ff;
   logic          p4_ok_ff;
   logic [PW-1:0] aden_ff;
   logic [NW1-1:0] ant_ff, anu_ff;
   logic [PW-1:0] p4_la_ff, p4_lb_ff;
   logic [RW-1:0] p4_ra_ff, p4_rb_ff;
   logic          dneg, t_sign_ok, u_sign_ok;

   always_comb begin
      dneg      = p3_den_ff[NW1-1];
      t_sign_ok = (nt_ff == '0) || (nt_ff[NTW-1] == dneg);
      u_sign_ok = (nu_ff == '0) || (nu_ff[NTW-1] == dneg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_v_ff <= 1'b0;
      end else if (adv) begin
         p4_v_ff <= p3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_ok_ff <= (p3_den_ff != '0) && t_sign_ok && u_sign_ok;
         aden_ff  <= PW'(dneg ? -p3_den_ff : p3_den_ff);
         ant_ff   <= NW1'(nt_ff[NTW-1] ? -nt_ff : nt_ff);
         anu_ff   <= NW1'(nu_ff[NTW-1] ? -nu_ff : nu_ff);
         p4_la_ff <= p3_la_ff;
         p4_lb_ff <= p3_lb_ff;
         p4_ra_ff <= p3_ra_ff;
         p4_rb_ff <= p3_rb_ff;
      end
   end

   // stage 5: quotients too large for any reach are rejected here
   logic           p5_v_ff;
   logic           p5_ok_ff;
   logic [PW-1:0]  p5_aden_ff;
   logic [PW-1:0]  rem_t_ff, rem_u_ff;
   logic [QB-1:0]  low_t_ff, low_u_ff;
   logic [PW-1:0]  p5_la_ff, p5_lb_ff;
   logic [RW-1:0]  p5_ra_ff, p5_rb_ff;
   logic [CPW-1:0] den_scaled;
   logic           ov_t, ov_u;

   always_comb begin
      den_scaled = {aden_ff, {(CW-1){1'b0}}};
      ov_t       = ({{(CW-2){1'b0}}, ant_ff} >= den_scaled);
      ov_u       = ({{(CW-2){1'b0}}, anu_ff} >= den_scaled);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_v_ff <= 1'b0;
      end else if (adv) begin
         p5_v_ff <= p4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p5_ok_ff   <= p4_ok_ff && !ov_t && !ov_u;
         p5_aden_ff <= aden_ff;
         rem_t_ff   <= PW'(ant_ff >> (CW - 1));
         rem_u_ff   <= PW'(anu_ff >> (CW - 1));
         low_t_ff   <= {ant_ff[CW-2:0], {FB{1'b0}}};
         low_u_ff   <= {anu_ff[CW-2:0], {FB{1'b0}}};
         p5_la_ff   <= p4_la_ff;
         p5_lb_ff   <= p4_lb_ff;
         p5_ra_ff   <= p4_ra_ff;
         p5_rb_ff   <= p4_rb_ff;
      end
   end

   // quotient pipelines for t and u
   logic           div_t_v, div_u_v;
   logic [QB-1:0]  q_t, q_u;
   logic [DTW-1:0] dtag_t, dtag_u;

   assign div_ctl = '{adv: adv, valid: p5_v_ff};

   rsi_divider #(.DVW(PW), .QB(QB), .TW(DTW)) u_div_t (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .divisor  (p5_aden_ff),
      .rem_init (rem_t_ff),
      .low_bits (low_t_ff),
      .tag_i    ({p5_ok_ff, p5_ra_ff, p5_la_ff}),
      .valid_o  (div_t_v),
      .quot_o   (q_t),
      .tag_o    (dtag_t)
   );

   rsi_divider #(.DVW(PW), .QB(QB), .TW(DTW)) u_div_u (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .divisor  (p5_aden_ff),
      .rem_init (rem_u_ff),
      .low_bits (low_u_ff),
      .tag_i    ({p5_ok_ff, p5_rb_ff, p5_lb_ff}),
      .valid_o  (div_u_v),
      .quot_o   (q_u),
      .tag_o    (dtag_u)
   );

   // saturated time along ray a
   logic [RW-1:0] t_sat;

   assign t_sat = (q_t[QB-1:RW] != '0) ? {RW{1'b1}} : q_t[RW-1:0];

   // reach tests
   logic           rch_t_v, rch_u_v, pass_t, pass_u;
   logic [RTW-1:0] rtag_t;
   logic           rtag_u;

   assign rch_ctl_t = '{adv: adv, valid: div_t_v};
   assign rch_ctl_u = '{adv: adv, valid: div_u_v};

   rsi_reach #(.QB(QB), .LW(PW), .RW(RW), .FB(FB), .TW(RTW)) u_reach_t (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rch_ctl_t),
      .quot    (q_t),
      .len2    (dtag_t[PW-1:0]),
      .reach   (dtag_t[PW +: RW]),
      .tag_i   ({dtag_t[DTW-1], t_sat}),
      .valid_o (rch_t_v),
      .pass_o  (pass_t),
      .tag_o   (rtag_t)
   );

   rsi_reach #(.QB(QB), .LW(PW), .RW(RW), .FB(FB), .TW(1)) u_reach_u (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rch_ctl_u),
      .quot    (q_u),
      .len2    (dtag_u[PW-1:0]),
      .reach   (dtag_u[PW +: RW]),
      .tag_i   (dtag_u[DTW-1]),
      .valid_o (rch_u_v),
      .pass_o  (pass_u),
      .tag_o   (rtag_u)
   );

   // output register
   logic          hit_in;
   logic          hit_ff;
   logic [RW-1:0] hit_time_ff;

   assign hit_in = rtag_t[RTW-1] && rtag_u && pass_t && pass_u;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rch_t_v && rch_u_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff      <= hit_in;
         hit_time_ff <= hit_in ? rtag_t[RW-1:0] : '0;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.hit      = hit_ff;
   assign rsp_chan.hit_time = hit_time_ff;

   // checks
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

   a_miss_time_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.hit |-> rsp_chan.hit_time == '0)
      else $error("miss reported with nonzero time");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input taken while result stalled");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      rch_t_v == rch_u_v && div_t_v == div_u_v)
      else $error("t and u pipelines out of step");

endmodule

// ----- hdl/rsi_divider.sv -----
// ----------------------------------------------------------------------------
// rsi_divider
// Pipelined restoring divider, one quotient bit per stage, with a sideband tag.
// ----------------------------------------------------------------------------
module rsi_divider #(
   parameter int DVW = 64,
   parameter int QB  = 47,
   parameter int TW  = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rsi_pkg::rsi_ctl_type ctl,
   input  logic [DVW-1:0]       divisor,
   input  logic [DVW-1:0]       rem_init,
   input  logic [QB-1:0]        low_bits,
   input  logic [TW-1:0]        tag_i,
   output logic                 valid_o,
   output logic [QB-1:0]        quot_o,
   output logic [TW-1:0]        tag_o
);
   import rsi_pkg::*;

   logic            v_ff    [0:QB];
   logic [QB-1:0]   quot_ff [0:QB];
   logic [TW-1:0]   tag_ff  [0:QB];
   logic [DVW-1:0]  dvs_ff  [0:QB-1];
   logic [DVW-1:0]  rem_ff  [0:QB-1];
   logic [QB-1:0]   low_ff  [0:QB-1];

   // entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (ctl.adv) begin
         v_ff[0] <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         dvs_ff[0]  <= divisor;
         rem_ff[0]  <= rem_init;
         low_ff[0]  <= low_bits;
         quot_ff[0] <= '0;
         tag_ff[0]  <= tag_i;
      end
   end

   // one compare and subtract per stage
   for (genvar k = 0; k < QB; k++) begin : g_step
      logic [DVW:0]   trial;
      logic           fits;
      logic [DVW-1:0] rem_in;
      logic [QB-1:0]  quot_in;

      always_comb begin
         trial   = {rem_ff[k], low_ff[k][QB-1]};
         fits    = (trial >= {1'b0, dvs_ff[k]});
         rem_in  = fits ? DVW'(trial - {1'b0, dvs_ff[k]}) : trial[DVW-1:0];
         quot_in = {quot_ff[k][QB-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (ctl.adv) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.adv) begin
            quot_ff[k+1] <= quot_in;
            tag_ff[k+1]  <= tag_ff[k];
         end
      end

      if (k < QB - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (ctl.adv) begin
               dvs_ff[k+1] <= dvs_ff[k];
               rem_ff[k+1] <= rem_in;
               low_ff[k+1] <= low_ff[k] << 1;
            end
         end
      end
   end

   assign valid_o = v_ff[QB];
   assign quot_o  = quot_ff[QB];
   assign tag_o   = tag_ff[QB];

endmodule

// ----- hdl/rsi_reach.sv -----
// ----------------------------------------------------------------------------
// rsi_reach
// Pipelined exact reach test: q^2 * len2 < reach^2 * 2^(2*FB).
// ----------------------------------------------------------------------------
module rsi_reach #(
   parameter int QB = 47,
   parameter int LW = 64,
   parameter int RW = 31,
   parameter int FB = 16,
   parameter int TW = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rsi_pkg::rsi_ctl_type ctl,
   input  logic [QB-1:0]        quot,
   input  logic [LW-1:0]        len2,
   input  logic [RW-1:0]        reach,
   input  logic [TW-1:0]        tag_i,
   output logic                 valid_o,
   output logic                 pass_o,
   output logic [TW-1:0]        tag_o
);
   import rsi_pkg::*;

   localparam int H    = (QB + 1) / 2;
   localparam int HW   = QB - H;
   localparam int Q2W  = 2 * QB;
   localparam int D    = MUL_DIGIT_W;
   localparam int NDIG = (LW + D - 1) / D;
   localparam int LPW  = NDIG * D;
   localparam int AW   = Q2W + LW;
   localparam int RRW  = 2 * RW;

   // stage 1: partial squares of the quotient, square of the reach
   logic            s1_v_ff;
   logic [2*HW-1:0] hh_ff;
   logic [H+HW-1:0] hl_ff;
   logic [2*H-1:0]  ll_ff;
   logic [RRW-1:0]  s1_rr_ff;
   logic [LW-1:0]   s1_len_ff;
   logic [TW-1:0]   s1_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (ctl.adv) begin
         s1_v_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         hh_ff     <= (2*HW)'(quot[QB-1:H]) * (2*HW)'(quot[QB-1:H]);
         hl_ff     <= (H+HW)'(quot[QB-1:H]) * (H+HW)'(quot[H-1:0]);
         ll_ff     <= (2*H)'(quot[H-1:0]) * (2*H)'(quot[H-1:0]);
         s1_rr_ff  <= RRW'(reach) * RRW'(reach);
         s1_len_ff <= len2;
         s1_tag_ff <= tag_i;
      end
   end

   // digit stages: index 0 holds the assembled square, acc builds q^2 * len2
   logic            d_v_ff   [0:NDIG];
   logic [Q2W-1:0]  d_q2_ff  [0:NDIG-1];
   logic [LPW-1:0]  d_len_ff [0:NDIG-1];
   logic [RRW-1:0]  d_rr_ff  [0:NDIG];
   logic [AW-1:0]   d_acc_ff [0:NDIG];
   logic [TW-1:0]   d_tag_ff [0:NDIG];

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff[0] <= 1'b0;
      end else if (ctl.adv) begin
         d_v_ff[0] <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         d_q2_ff[0]  <= (Q2W'(hh_ff) << (2 * H)) + (Q2W'(hl_ff) << (H + 1))
                        + Q2W'(ll_ff);
         d_len_ff[0] <= LPW'(s1_len_ff);
         d_rr_ff[0]  <= s1_rr_ff;
         d_acc_ff[0] <= '0;
         d_tag_ff[0] <= s1_tag_ff;
      end
   end

   for (genvar m = 0; m < NDIG; m++) begin : g_digit
      logic [Q2W+D-1:0] part;
      logic [AW-1:0]    acc_in;

      always_comb begin
         part   = (Q2W+D)'(d_q2_ff[m]) * (Q2W+D)'(d_len_ff[m][m*D +: D]);
         acc_in = d_acc_ff[m] + (AW'(part) << (m * D));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d_v_ff[m+1] <= 1'b0;
         end else if (ctl.adv) begin
            d_v_ff[m+1] <= d_v_ff[m];
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.adv) begin
            d_acc_ff[m+1] <= acc_in;
            d_rr_ff[m+1]  <= d_rr_ff[m];
            d_tag_ff[m+1] <= d_tag_ff[m];
         end
      end

      if (m < NDIG - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (ctl.adv) begin
               d_q2_ff[m+1]  <= d_q2_ff[m];
               d_len_ff[m+1] <= d_len_ff[m];
            end
         end
      end
   end

   // final compare against the scaled reach square
   logic          f_v_ff;
   logic          f_pass_ff;
   logic [TW-1:0] f_tag_ff;
   logic [AW-1:0] rhs;

   assign rhs = {{(AW-RRW-2*FB){1'b0}}, d_rr_ff[NDIG], {(2*FB){1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (ctl.adv) begin
         f_v_ff <= d_v_ff[NDIG];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         f_pass_ff <= (d_acc_ff[NDIG] < rhs);
         f_tag_ff  <= d_tag_ff[NDIG];
      end
   end

   assign valid_o = f_v_ff;
   assign pass_o  = f_pass_ff;
   assign tag_o   = f_tag_ff;

endmodule
